/* hdl/qtg_pkg.sv */
// Shared constants, types and tables of the quadrature tone generator.
`default_nettype none

package qtg_pkg;

    localparam int RATE_W       = 20;
    localparam int COUNT_W      = 32;
    localparam int PHASE_BITS   = 24;
    localparam int AMP_BITS     = 16;
    localparam int TURN_W       = 32;
    localparam int DIV_W        = (PHASE_BITS > RATE_W) ? PHASE_BITS : RATE_W;
    localparam int DIV_SHIFT    = DIV_W - RATE_W;
    localparam int CORDIC_STEPS = 24;
    localparam int XY_W         = 25;
    localparam int Z_W          = TURN_W;
    localparam int UNIT_SHIFT   = 22;
    localparam int CORDIC_X0    = 2547003;
    localparam int PROD_W       = XY_W + AMP_BITS;
    localparam int MAX_STEPS    = (DIV_W > CORDIC_STEPS) ? DIV_W : CORDIC_STEPS;
    localparam int CNT_W        = $clog2(MAX_STEPS);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = COUNT_W;

    localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(48000);
    localparam logic [RATE_W-1:0]  TONE_RESET  = RATE_W'(1000);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(48000);

    localparam logic signed [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE  = 2'd0,
        CFG_TONE_FREQ    = 2'd1,
        CFG_SAMPLE_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_TONE  = 2'd0,
        DIV_PHASE = 2'd1,
        DIV_TURN  = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     restart;
        logic     div_load;
        t_div_sel div_sel;
        logic     div_step;
        logic     rot_load;
        logic     rot_step;
        logic     mul;
        logic     emit;
    } t_dp_cmd;

    typedef struct packed {
        logic run_ok;
        logic div_last;
        logic rot_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* hdl/qtg_in_if.sv */
// Tick channel: valid/ready handshake with the restart flag.
`default_nettype none

interface qtg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

/* hdl/qtg_out_if.sv */
// Sample channel: valid/ready handshake with the stereo sample payload.
`default_nettype none

interface qtg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qtg_pkg::AMP_BITS-1:0]  left_sample;
    logic signed [qtg_pkg::AMP_BITS-1:0]  right_sample;
    logic                                 last_sample;

    modport source (output valid, output left_sample, output right_sample,
                    output last_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample,
                  input last_sample, output ready);
endinterface

`default_nettype wire

/* hdl/quadrature_tone_generator_top.sv */
// Top level of the quadrature tone generator: sequencer plus datapath.
//   i_tick is the tick channel: each transaction asks for the next stereo
//   sample; restart = 1 zeroes the phase and the sample index first.
//   o_sample carries the sine (left) and cosine (right) sample and a flag
//   on the last sample of the programmed run. The configuration port writes
//   sample rate (index 0), tone frequency (index 1) and sample count
//   (index 2); the user must write only while the block is idle (not enforced).
// Sequence:
//   A tick that yields a sample is checked against the sample count, then a
//   shared restoring divider runs 20 + 20 + 24 steps (tone mod rate, phase
//   mod rate, turn fraction), the CORDIC rotator runs 24 steps, plus load,
//   multiply and output states. The next tick is taken only after the sample
//   is emitted. A tick past the sample count gives no sample.
// Reset: synchronous, active low: registers take 48000 / 1000 / 48000,
//   phase and index go to zero, the output register empties.
// Stalls: the output register holds a finished sample until taken; the next
//   tick is still accepted and its sample waits in the datapath until the
//   output register frees.
`default_nettype none

module quadrature_tone_generator_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    qtg_in_if.sink                                   i_tick,
    qtg_out_if.source                                o_sample,
    input  wire logic                                i_cfg_we,
    input  wire logic [qtg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [qtg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    qtg_pkg::t_dp_cmd dp_cmd;
    qtg_pkg::t_dp_sts dp_sts;

    qtg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_tick.valid),
        .i_in_restart (i_tick.restart),
        .o_in_ready   (i_tick.ready),
        .o_cmd        (dp_cmd),
        .i_sts        (dp_sts)
    );

    qtg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_ready (o_sample.ready),
        .o_out_valid (o_sample.valid),
        .o_left      (o_sample.left_sample),
        .o_right     (o_sample.right_sample),
        .o_last      (o_sample.last_sample)
    );

endmodule

`default_nettype wire

/* hdl/qtg_ctrl.sv */
// Sequencer of the tone generator: steps the divider, rotator and output.
`default_nettype none

module qtg_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_restart,
    output logic                  o_in_ready,
    output qtg_pkg::t_dp_cmd      o_cmd,
    input  wire qtg_pkg::t_dp_sts i_sts
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CHECK  = 11'b000_0000_0010,
        S_DIV_F  = 11'b000_0000_0100,
        S_LD_P   = 11'b000_0000_1000,
        S_DIV_P  = 11'b000_0001_0000,
        S_LD_U   = 11'b000_0010_0000,
        S_DIV_U  = 11'b000_0100_0000,
        S_LD_ROT = 11'b000_1000_0000,
        S_ROT    = 11'b001_0000_0000,
        S_MUL    = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.div_sel  = qtg_pkg::DIV_TONE;
        o_in_ready     = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.restart = i_in_restart;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.run_ok) begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_sel  = qtg_pkg::DIV_TONE;
                    n_state        = S_DIV_F;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV_F: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_LD_P;
                end
            end
            S_LD_P: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = qtg_pkg::DIV_PHASE;
                n_state        = S_DIV_P;
            end
            S_DIV_P: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_LD_U;
                end
            end
            S_LD_U: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = qtg_pkg::DIV_TURN;
                n_state        = S_DIV_U;
            end
            S_DIV_U: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_LD_ROT;
                end
            end
            S_LD_ROT: begin
                o_cmd.rot_load = 1'b1;
                n_state        = S_ROT;
            end
            S_ROT: begin
                o_cmd.rot_step = 1'b1;
                if (i_sts.rot_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/qtg_dp.sv */
// Datapath of the tone generator: registers, restoring divider, CORDIC, scaler.
`default_nettype none

module qtg_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [qtg_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [qtg_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire qtg_pkg::t_dp_cmd                      i_cmd,
    output qtg_pkg::t_dp_sts                           o_sts,
    input  wire logic                                  i_out_ready,
    output logic                                       o_out_valid,
    output logic signed [qtg_pkg::AMP_BITS-1:0]        o_left,
    output logic signed [qtg_pkg::AMP_BITS-1:0]        o_right,
    output logic                                       o_last
);

    localparam int RATE_W   = qtg_pkg::RATE_W;
    localparam int COUNT_W  = qtg_pkg::COUNT_W;
    localparam int DIV_W    = qtg_pkg::DIV_W;
    localparam int XY_W     = qtg_pkg::XY_W;
    localparam int Z_W      = qtg_pkg::Z_W;
    localparam int TURN_W   = qtg_pkg::TURN_W;
    localparam int PHASE_B  = qtg_pkg::PHASE_BITS;
    localparam int AMP_B    = qtg_pkg::AMP_BITS;
    localparam int PROD_W   = qtg_pkg::PROD_W;
    localparam int CNT_W    = qtg_pkg::CNT_W;

    localparam logic signed [PROD_W-1:0] AMP_P = PROD_W'((2 ** (AMP_B - 1)) - 1);
    localparam logic signed [PROD_W-1:0] BIAS_P =
        PROD_W'((2 ** qtg_pkg::UNIT_SHIFT) - 1);
    localparam logic signed [XY_W-1:0]   X0 = XY_W'(qtg_pkg::CORDIC_X0);

    function automatic logic signed [AMP_B-1:0] scale_out(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] adj;
        logic signed [PROD_W-1:0] sh;
        adj = p;
        if (p[PROD_W-1]) begin
            adj = p + BIAS_P;
        end
        sh = adj >>> qtg_pkg::UNIT_SHIFT;
        if (sh > AMP_P) begin
            sh = AMP_P;
        end else if (sh < -AMP_P) begin
            sh = -AMP_P;
        end
        return sh[AMP_B-1:0];
    endfunction

    logic [RATE_W-1:0]         r_rate;
    logic [RATE_W-1:0]         r_tone;
    logic [COUNT_W-1:0]        r_count;
    logic [RATE_W-1:0]         r_phase;
    logic [COUNT_W-1:0]        r_index;

    logic [RATE_W-1:0]         r_fm;
    logic [RATE_W-1:0]         r_p;
    logic [PHASE_B-1:0]        r_u;
    qtg_pkg::t_div_sel         r_div_sel;
    logic [RATE_W-1:0]         r_rem;
    logic [DIV_W-1:0]          r_bits;
    logic [CNT_W-1:0]          r_cnt;

    logic signed [XY_W-1:0]    r_x;
    logic signed [XY_W-1:0]    r_y;
    logic signed [Z_W-1:0]     r_z;
    logic [1:0]                r_q;
    logic signed [PROD_W-1:0]  r_prod_s;
    logic signed [PROD_W-1:0]  r_prod_c;

    logic                      r_out_valid;
    logic signed [AMP_B-1:0]   r_left;
    logic signed [AMP_B-1:0]   r_right;
    logic                      r_last;

    logic [RATE_W-1:0]         fs;
    logic [RATE_W:0]           div_t;
    logic [RATE_W:0]           div_diff;
    logic                      div_ge;
    logic [RATE_W-1:0]         n_rem;
    logic [DIV_W-1:0]          n_bits;
    logic                      div_last;
    logic                      rot_last;

    logic [TURN_W-1:0]         turn;
    logic signed [XY_W-1:0]    dx;
    logic signed [XY_W-1:0]    dy;
    logic signed [Z_W-1:0]     atan_k;
    logic signed [XY_W-1:0]    sin_v;
    logic signed [XY_W-1:0]    cos_v;

    logic [RATE_W:0]           phase_sum;
    logic [RATE_W-1:0]         n_phase;
    logic                      out_free;

    assign fs = (r_rate == '0) ? RATE_W'(1) : r_rate;

    assign div_t    = {r_rem, r_bits[DIV_W-1]};
    assign div_diff = div_t - {1'b0, fs};
    assign div_ge   = (div_t >= {1'b0, fs});
    assign n_rem    = div_ge ? div_diff[RATE_W-1:0] : div_t[RATE_W-1:0];
    assign n_bits   = {r_bits[DIV_W-2:0], div_ge};
    assign div_last = (r_div_sel == qtg_pkg::DIV_TURN) ? (r_cnt == CNT_W'(PHASE_B - 1))
                                                       : (r_cnt == CNT_W'(RATE_W - 1));
    assign rot_last = (r_cnt == CNT_W'(qtg_pkg::CORDIC_STEPS - 1));

    assign turn   = TURN_W'(r_u) << (TURN_W - PHASE_B);
    assign dx     = r_y >>> r_cnt;
    assign dy     = r_x >>> r_cnt;
    assign atan_k = (r_cnt < CNT_W'(qtg_pkg::CORDIC_STEPS)) ? qtg_pkg::ATAN_TURNS[r_cnt] : '0;

    always_comb begin
        case (r_q)
            2'd0: begin
                sin_v = r_y;
                cos_v = r_x;
            end
            2'd1: begin
                sin_v = r_x;
                cos_v = -r_y;
            end
            2'd2: begin
                sin_v = -r_y;
                cos_v = -r_x;
            end
            default: begin
                sin_v = -r_x;
                cos_v = r_y;
            end
        endcase
    end

    assign phase_sum = {1'b0, r_p} + {1'b0, r_fm};
    assign n_phase   = (phase_sum >= {1'b0, fs}) ? RATE_W'(phase_sum - {1'b0, fs})
                                                 : phase_sum[RATE_W-1:0];
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= qtg_pkg::RATE_RESET;
            r_tone  <= qtg_pkg::TONE_RESET;
            r_count <= qtg_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            case (qtg_pkg::t_cfg_idx'(i_cfg_idx))
                qtg_pkg::CFG_SAMPLE_RATE:  r_rate  <= i_cfg_data[RATE_W-1:0];
                qtg_pkg::CFG_TONE_FREQ:    r_tone  <= i_cfg_data[RATE_W-1:0];
                qtg_pkg::CFG_SAMPLE_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_index <= '0;
        end else if (i_cmd.restart) begin
            r_phase <= '0;
            r_index <= '0;
        end else if (i_cmd.emit) begin
            r_phase <= n_phase;
            r_index <= r_index + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div_sel <= i_cmd.div_sel;
            r_cnt     <= '0;
            case (i_cmd.div_sel)
                qtg_pkg::DIV_TONE: begin
                    r_rem  <= '0;
                    r_bits <= DIV_W'(r_tone) << qtg_pkg::DIV_SHIFT;
                end
                qtg_pkg::DIV_PHASE: begin
                    r_rem  <= '0;
                    r_bits <= DIV_W'(r_phase) << qtg_pkg::DIV_SHIFT;
                end
                qtg_pkg::DIV_TURN: begin
                    r_rem  <= r_p;
                    r_bits <= '0;
                end
                default: begin
                    r_rem  <= '0;
                    r_bits <= '0;
                end
            endcase
        end else if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_bits <= n_bits;
            r_cnt  <= r_cnt + CNT_W'(1);
            if (div_last) begin
                case (r_div_sel)
                    qtg_pkg::DIV_TONE:  r_fm <= n_rem;
                    qtg_pkg::DIV_PHASE: r_p  <= n_rem;
                    qtg_pkg::DIV_TURN:  r_u  <= n_bits[PHASE_B-1:0];
                    default: begin
                    end
                endcase
            end
        end else if (i_cmd.rot_load) begin
            r_cnt <= '0;
            r_x   <= X0;
            r_y   <= '0;
            r_z   <= {{2{turn[TURN_W-3]}}, turn[TURN_W-3:0]};
            r_q   <= turn[TURN_W-1:TURN_W-2] + {1'b0, turn[TURN_W-3]};
        end else if (i_cmd.rot_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_k;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_k;
            end
        end
        if (i_cmd.mul) begin
            r_prod_s <= PROD_W'(sin_v) * AMP_P;
            r_prod_c <= PROD_W'(cos_v) * AMP_P;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_left  <= scale_out(r_prod_s);
            r_right <= scale_out(r_prod_c);
            r_last  <= (r_index == (r_count - COUNT_W'(1)));
        end
    end

    assign o_sts.run_ok   = (r_index < r_count);
    assign o_sts.div_last = div_last;
    assign o_sts.rot_last = rot_last;
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_left      = r_left;
    assign o_right     = r_right;
    assign o_last      = r_last;

endmodule

`default_nettype wire
